// ===== rtl/murmur64a_hash_stream_unit_macros.svh =====
// assertion macros for the murmur64a hash stream unit checker
// no dependencies; each macro expands to one labelled concurrent assertion on clk
`ifndef MURMUR64A_HASH_STREAM_UNIT_MACROS_SVH
`define MURMUR64A_HASH_STREAM_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define M64H_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define M64H_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/m64h_pkg.sv =====
// shared constants, control word type and microcode table for the murmur64a hash unit
// no dependencies; imported by murmur64a_hash_stream_unit
package m64h_pkg;

  // hash constants
  localparam logic [63:0] MUL_M      = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MUL_M_LO   = MUL_M[31:0];
  localparam logic [31:0] MUL_M_HI   = MUL_M[63:32];
  localparam int          SHIFT_R    = 47;
  localparam logic [63:0] SEED_RESET = 64'd22;

  // stream field widths
  localparam int WORD_W   = 64;
  localparam int TAIL_W   = 4;
  localparam int LEN_W    = 32;
  localparam int IN_BITS  = WORD_W + TAIL_W + LEN_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 64;
  localparam int BYTES_PER_WORD = WORD_W / 8;

  // sequencer
  localparam int PC_W = 5;

  // datapath operations
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_MUL_LL = 4'd1;  // acc = src_lo * m_lo
  localparam logic [3:0] OP_MUL_LH = 4'd2;  // acc += (src_lo * m_hi) << 32
  localparam logic [3:0] OP_MUL_HL = 4'd3;  // acc += (src_hi * m_lo) << 32
  localparam logic [3:0] OP_H_SEED = 4'd4;  // h = seed ^ acc
  localparam logic [3:0] OP_H_TAIL = 4'd5;  // h = h ^ (k & byte mask)
  localparam logic [3:0] OP_H_ACC  = 4'd6;  // h = acc
  localparam logic [3:0] OP_K_XS   = 4'd7;  // k = acc ^ (acc >> 47)
  localparam logic [3:0] OP_H_XOR  = 4'd8;  // h = h ^ acc
  localparam logic [3:0] OP_H_XS   = 4'd9;  // h = h ^ (h >> 47)
  localparam logic [3:0] OP_FIN    = 4'd10; // h = acc ^ (acc >> 47), emit

  // multiplier source
  localparam logic [1:0] SRC_K   = 2'd0;
  localparam logic [1:0] SRC_H   = 2'd1;
  localparam logic [1:0] SRC_LEN = 2'd2;

  // jump conditions
  localparam logic [2:0] C_NONE      = 3'd0;
  localparam logic [2:0] C_ALWAYS    = 3'd1;
  localparam logic [2:0] C_NOT_FIRST = 3'd2;
  localparam logic [2:0] C_FULL_MIX  = 3'd3;  // not last, or eight or more tail bytes
  localparam logic [2:0] C_TAIL_ZERO = 3'd4;
  localparam logic [2:0] C_NOT_LAST  = 3'd5;

  // program labels
  localparam logic [PC_W-1:0] PC_MIXSEL = 5'd5;
  localparam logic [PC_W-1:0] PC_FULL   = 5'd12;
  localparam logic [PC_W-1:0] PC_FIN    = 5'd24;

  // one control word; a taken condition either jumps or, with done set, ends the request
  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      src;
    logic [2:0]      cond;
    logic            done;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t cw(logic [3:0] op, logic [1:0] src, logic [2:0] cond,
                                    logic done, logic [PC_W-1:0] target);
    ctrl_word_t w;
    w.op = op;
    w.src = src;
    w.cond = cond;
    w.done = done;
    w.target = target;
    return w;
  endfunction

  // microcode rom
  function automatic ctrl_word_t m64h_ucode(logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      // start: skip seeding unless this is the first word
      5'd0:  w = cw(OP_NOP,    SRC_K,   C_NOT_FIRST, 1'b0, PC_MIXSEL);
      // h = seed ^ (len * m)
      5'd1:  w = cw(OP_MUL_LL, SRC_LEN, C_NONE,      1'b0, '0);
      5'd2:  w = cw(OP_MUL_LH, SRC_LEN, C_NONE,      1'b0, '0);
      5'd3:  w = cw(OP_MUL_HL, SRC_LEN, C_NONE,      1'b0, '0);
      5'd4:  w = cw(OP_H_SEED, SRC_K,   C_NONE,      1'b0, '0);
      // choose the kind of mixing
      5'd5:  w = cw(OP_NOP,    SRC_K,   C_FULL_MIX,  1'b0, PC_FULL);
      5'd6:  w = cw(OP_NOP,    SRC_K,   C_TAIL_ZERO, 1'b0, PC_FIN);
      // partial tail: h ^= bytes, h *= m
      5'd7:  w = cw(OP_H_TAIL, SRC_K,   C_NONE,      1'b0, '0);
      5'd8:  w = cw(OP_MUL_LL, SRC_H,   C_NONE,      1'b0, '0);
      5'd9:  w = cw(OP_MUL_LH, SRC_H,   C_NONE,      1'b0, '0);
      5'd10: w = cw(OP_MUL_HL, SRC_H,   C_NONE,      1'b0, '0);
      5'd11: w = cw(OP_H_ACC,  SRC_K,   C_ALWAYS,    1'b0, PC_FIN);
      // full word: k *= m, k ^= k >> 47
      5'd12: w = cw(OP_MUL_LL, SRC_K,   C_NONE,      1'b0, '0);
      5'd13: w = cw(OP_MUL_LH, SRC_K,   C_NONE,      1'b0, '0);
      5'd14: w = cw(OP_MUL_HL, SRC_K,   C_NONE,      1'b0, '0);
      5'd15: w = cw(OP_K_XS,   SRC_K,   C_NONE,      1'b0, '0);
      // k *= m, h ^= k
      5'd16: w = cw(OP_MUL_LL, SRC_K,   C_NONE,      1'b0, '0);
      5'd17: w = cw(OP_MUL_LH, SRC_K,   C_NONE,      1'b0, '0);
      5'd18: w = cw(OP_MUL_HL, SRC_K,   C_NONE,      1'b0, '0);
      5'd19: w = cw(OP_H_XOR,  SRC_K,   C_NONE,      1'b0, '0);
      // h *= m; a word that is not last ends here
      5'd20: w = cw(OP_MUL_LL, SRC_H,   C_NONE,      1'b0, '0);
      5'd21: w = cw(OP_MUL_LH, SRC_H,   C_NONE,      1'b0, '0);
      5'd22: w = cw(OP_MUL_HL, SRC_H,   C_NONE,      1'b0, '0);
      5'd23: w = cw(OP_H_ACC,  SRC_K,   C_NOT_LAST,  1'b1, '0);
      // finalisation: h ^= h >> 47, h *= m, h ^= h >> 47
      5'd24: w = cw(OP_H_XS,   SRC_K,   C_NONE,      1'b0, '0);
      5'd25: w = cw(OP_MUL_LL, SRC_H,   C_NONE,      1'b0, '0);
      5'd26: w = cw(OP_MUL_LH, SRC_H,   C_NONE,      1'b0, '0);
      5'd27: w = cw(OP_MUL_HL, SRC_H,   C_NONE,      1'b0, '0);
      5'd28: w = cw(OP_FIN,    SRC_K,   C_ALWAYS,    1'b1, '0);
      default: w = cw(OP_NOP,  SRC_K,   C_ALWAYS,    1'b1, '0);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/murmur64a_hash_stream_unit.sv =====
// murmur64a streaming hash unit: microcoded sequencer over one shared 32x32 multiplier
// depends on m64h_pkg (constants, control word type, microcode rom)
//
// Usage
//   The key arrives on the in_ stream as 64-bit little-endian words. in_tuser marks the
//   first word of a key (its total_length field seeds the hash), in_tlast the final word,
//   whose tail_bytes field gives its valid bytes (0 to 8, larger counts act as 8).
//   One finalised 64-bit hash leaves on the out_ stream per final word; other words give
//   no result. The user must load the seed (cfg_wr_en / cfg_wr_data) only while the unit
//   is idle; the unit leaves this to the user. A single word is taken at a time. Each
//   64-bit multiply by the constant is split into partial products on the one 32x32
//   multiplier; the sequencer steps once a cycle unless the emitting step holds. A first
//   word also seeds the hash, and a final word mixes its block or its tail bytes, if any,
//   before finalisation. out_tvalid rises in the cycle after the final step.
//   When the receiver stalls, the result waits in the output register and the unit keeps
//   taking words; only the emitting step holds while an older result is still unsent.
//   Reset (rst_n low, synchronous) clears the running hash to zero, the seed to 22 and
//   drops all valid flags.
module murmur64a_hash_stream_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // data_word [63:0], tail_bytes [67:64], total_length [99:68], zero pad
  input  logic [m64h_pkg::IN_TDATA_W-1:0]    in_tdata,
  // first_word
  input  logic                               in_tuser,
  // last_word
  input  logic                               in_tlast,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hash_value [63:0]
  output logic [m64h_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // seed register
  input  logic                               cfg_wr_en,
  input  logic [63:0]                        cfg_wr_data
);
  import m64h_pkg::*;

  // control state
  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            out_valid_r, out_valid_nxt;

  // datapath registers
  logic [63:0]       seed_r;
  logic [63:0]       h_r, h_nxt;
  logic [63:0]       k_r, k_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [63:0]       out_data_r, out_data_nxt;
  logic              first_r, last_r;
  logic [TAIL_W-1:0] tail_r;
  logic [LEN_W-1:0]  len_r;

  ctrl_word_t  ucw;
  logic        in_acc;
  logic        stall;
  logic        step_go;
  logic        cond_true;
  logic [63:0] src_val;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] tail_mask;

  assign ucw       = m64h_ucode(pc_r);
  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign stall     = (ucw.op == OP_FIN) && out_valid_r && !out_tready;
  assign step_go   = busy_r && !stall;

  // condition select
  always_comb begin
    case (ucw.cond)
      C_NONE:      cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_NOT_FIRST: cond_true = !first_r;
      C_FULL_MIX:  cond_true = !last_r || (tail_r >= 4'(BYTES_PER_WORD));
      C_TAIL_ZERO: cond_true = (tail_r == '0);
      C_NOT_LAST:  cond_true = !last_r;
      default:     cond_true = 1'b0;
    endcase
  end

  // multiplier operand select
  always_comb begin
    case (ucw.src)
      SRC_K:   src_val = k_r;
      SRC_H:   src_val = h_r;
      SRC_LEN: src_val = {32'd0, len_r};
      default: src_val = k_r;
    endcase
  end

  // shared 32x32 multiplier, partial products of x * m modulo 2^64
  assign mul_a = (ucw.op == OP_MUL_HL) ? src_val[63:32] : src_val[31:0];
  assign mul_b = (ucw.op == OP_MUL_LH) ? MUL_M_HI : MUL_M_LO;
  assign prod  = mul_a * mul_b;

  // byte mask for a partial tail
  always_comb begin
    for (int i = 0; i < BYTES_PER_WORD; i++) begin
      tail_mask[8*i +: 8] = (4'(i) < tail_r) ? 8'hff : 8'h00;
    end
  end

  // sequencer and datapath next state
  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    if (in_acc) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
      k_nxt    = in_tdata[WORD_W-1:0];
    end

    if (step_go) begin
      case (ucw.op)
        OP_NOP:    ;
        OP_MUL_LL: acc_nxt = prod;
        OP_MUL_LH: acc_nxt = acc_r + {prod[31:0], 32'd0};
        OP_MUL_HL: acc_nxt = acc_r + {prod[31:0], 32'd0};
        OP_H_SEED: h_nxt = seed_r ^ acc_r;
        OP_H_TAIL: h_nxt = h_r ^ (k_r & tail_mask);
        OP_H_ACC:  h_nxt = acc_r;
        OP_K_XS:   k_nxt = acc_r ^ (acc_r >> SHIFT_R);
        OP_H_XOR:  h_nxt = h_r ^ acc_r;
        OP_H_XS:   h_nxt = h_r ^ (h_r >> SHIFT_R);
        OP_FIN: begin
          h_nxt         = acc_r ^ (acc_r >> SHIFT_R);
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r ^ (acc_r >> SHIFT_R);
        end
        default: ;
      endcase

      if (cond_true) begin
        if (ucw.done) begin
          busy_nxt = 1'b0;
        end else begin
          pc_nxt = ucw.target;
        end
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= SEED_RESET;
      h_r         <= '0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      first_r <= in_tuser;
      last_r  <= in_tlast;
      tail_r  <= in_tdata[WORD_W +: TAIL_W];
      len_r   <= in_tdata[WORD_W + TAIL_W +: LEN_W];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/m64h_checker.sv =====
// port-level checker for murmur64a_hash_stream_unit, bound to the top level
// depends on m64h_pkg and murmur64a_hash_stream_unit_macros.svh
`include "murmur64a_hash_stream_unit_macros.svh"

module m64h_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [m64h_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import m64h_pkg::*;

  // a pending result is held until taken
  `M64H_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped before taken")

  // a stalled result keeps its value
  `M64H_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "stalled result changed")

  // one word at a time: ready drops after an accepted request
  `M64H_ASSERT_NEXT(a_one_word, in_tvalid && in_tready, !in_tready, "second request taken while busy")

  // no result is produced in the cycle right after a request is taken
  `M64H_ASSERT_NEXT(a_no_early_result, in_tvalid && in_tready && !out_tvalid, !out_tvalid,
    "result appeared without sequencing")

endmodule

bind murmur64a_hash_stream_unit m64h_checker u_m64h_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/murmur64a_hash_stream_unit_test.sv =====
// self-checking testbench for the murmur64a hash stream unit: keys, seeds and stalls
// depends on m64h_pkg and murmur64a_hash_stream_unit; a built-in hash tracker checks out_tdata
module murmur64a_hash_stream_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import m64h_pkg::*;

  localparam int TAIL_LSB   = WORD_W;
  localparam int LEN_LSB    = WORD_W + TAIL_W;
  localparam int SETTLE     = 40;
  localparam int LONG_HOLD  = 400;

  // tracks the running hash per key and the hashes still owed by the unit
  class murmur_hash_tracker;
    logic [63:0] hash_seed;
    logic [63:0] key_hash;
    logic [63:0] hash_expected_q[$];
    int unsigned mismatches;

    function new();
      hash_seed = SEED_RESET;
      key_hash = '0;
      mismatches = 0;
    endfunction

    // full eight byte block folded into the hash
    function logic [63:0] scramble_block(logic [63:0] h, logic [63:0] k);
      k = k * MUL_M;
      k = k ^ (k >> SHIFT_R);
      k = k * MUL_M;
      h = h ^ k;
      return h * MUL_M;
    endfunction

    function logic [63:0] avalanche(logic [63:0] h);
      h = h ^ (h >> SHIFT_R);
      h = h * MUL_M;
      return h ^ (h >> SHIFT_R);
    endfunction

    // advance the key hash by one accepted request
    function void note_word(logic [63:0] word, logic is_first, logic is_last,
                            logic [3:0] tail, logic [31:0] key_len);
      logic [63:0] h;
      int unsigned n_tail;
      logic [63:0] byte_mask;
      h = key_hash;
      if (is_first)
        h = hash_seed ^ ({32'd0, key_len} * MUL_M);
      if (!is_last) begin
        key_hash = scramble_block(h, word);
        return;
      end
      n_tail = (tail > BYTES_PER_WORD) ? BYTES_PER_WORD : tail;
      if (n_tail == BYTES_PER_WORD) begin
        h = scramble_block(h, word);
      end else if (n_tail != 0) begin
        byte_mask = (64'd1 << (n_tail * 8)) - 64'd1;
        h = (h ^ (word & byte_mask)) * MUL_M;
      end
      h = avalanche(h);
      key_hash = h;
      hash_expected_q.push_back(h);
    endfunction

    function void check_hash(logic [63:0] actual);
      logic [63:0] want;
      if (hash_expected_q.size() == 0) begin
        $display("%0t: unexpected hash, expected none actual %h", $time, actual);
        mismatches++;
        return;
      end
      want = hash_expected_q.pop_front();
      if (actual !== want) begin
        $display("%0t: hash_value mismatch, expected %h actual %h", $time, want, actual);
        mismatches++;
      end
    endfunction

    function int pending();
      return hash_expected_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [63:0]            cfg_wr_data;

  murmur_hash_tracker tracker = new();
  bit quiet    = 1'b0;
  bit no_gaps  = 1'b0;
  bit hold_req = 1'b0;

  murmur64a_hash_stream_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // sample handshakes and seed writes at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        tracker.check_hash(out_tdata[63:0]);
      if (in_tvalid && in_tready)
        tracker.note_word(in_tdata[WORD_W-1:0], in_tuser, in_tlast,
                          in_tdata[TAIL_LSB +: TAIL_W], in_tdata[LEN_LSB +: LEN_W]);
      if (cfg_wr_en)
        tracker.hash_seed = cfg_wr_data;
    end
  end

  // result side back-pressure: short random bursts, one long hold on request
  initial begin
    int unsigned stall_len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall_len = LONG_HOLD;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_len = $urandom_range(1, 15);
      end else begin
        stall_len = 0;
      end
      if (stall_len != 0) begin
        out_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // run limit
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_word(input logic [63:0] word, input logic is_first, input logic is_last,
                           input logic [3:0] tail, input logic [31:0] key_len);
    logic [IN_TDATA_W-1:0] packed_req;
    packed_req = '0;
    packed_req[WORD_W-1:0] = word;
    packed_req[TAIL_LSB +: TAIL_W] = tail;
    packed_req[LEN_LSB +: LEN_W] = key_len;
    in_tdata  <= packed_req;
    in_tuser  <= is_first;
    in_tlast  <= is_last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_gap();
    if (!quiet && !no_gaps && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // sender pause until every hash is back and the unit has gone quiet
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // well-formed key; the length field is honest or random
  task automatic send_key(input int unsigned n_words, input logic [3:0] tail,
                          input bit honest_len);
    logic [31:0] key_len;
    int unsigned i;
    if (honest_len)
      key_len = 32'((n_words - 1) * BYTES_PER_WORD +
                    ((tail > BYTES_PER_WORD) ? BYTES_PER_WORD : tail));
    else
      key_len = $urandom;
    for (i = 0; i < n_words; i++) begin
      send_word(rand64(), i == 0, i == n_words - 1,
                (i == n_words - 1) ? tail : 4'($urandom_range(0, 15)),
                (i == 0) ? key_len : $urandom);
      idle_gap();
    end
  endtask

  // mostly keys with random content, some loose words with random marks
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_words;
    logic [3:0] tail;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(rand64(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  4'($urandom_range(0, 15)), $urandom);
        idle_gap();
        sent++;
      end else begin
        n_words = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
        tail = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, BYTES_PER_WORD));
        send_key(n_words, tail, $urandom_range(0, 3) != 0);
        sent += n_words;
      end
    end
  endtask

  task automatic run_phase(input logic [63:0] seed_value, input int unsigned n_items);
    settle_idle();
    write_seed(seed_value);
    run_random(n_items);
  endtask

  initial begin
    int unsigned t;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    in_tlast    <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: continuation from a cleared hash, then from a finished key
    send_word(rand64(), 1'b0, 1'b0, 4'd5, 32'd0);
    send_word(rand64(), 1'b0, 1'b1, 4'd8, 32'd0);
    send_word('1, 1'b0, 1'b1, 4'd3, '1);
    // single word keys: empty, full at the extremes, oversized tail count
    send_word(rand64(), 1'b1, 1'b1, 4'd0, 32'd0);
    send_word('1, 1'b1, 1'b1, 4'd8, '1);
    send_word('0, 1'b1, 1'b1, 4'd15, 32'd8);
    // every partial tail length
    for (t = 1; t < BYTES_PER_WORD; t++)
      send_key(2, 4'(t), 1'b1);

    run_phase('0, 150);
    run_phase('1, 150);
    run_phase(rand64(), 150);

    // receiver holds off while the sender keeps offering
    settle_idle();
    write_seed(64'h8000_0000_0000_0000);
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    run_random(60);
    no_gaps = 1'b0;

    run_phase(rand64(), 120);
    quiet = 1'b1;
    run_phase(rand64(), 120);

    settle_idle();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
